>>> rtl/core/mrfp_pkg.sv
// Shared types and constants for the meter response frame parser.
// Holds the beat structs, frame byte codes, status and kind codes, register tables.
// No dependencies.
package mrfp_pkg;

	// Frame byte codes
	localparam logic [7:0] SYNC_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE  = 8'h16;
	localparam logic [7:0] MASK_BYTE = 8'h33;
	localparam logic [7:0] CTRL_DATA = 8'h91;
	localparam logic [7:0] CTRL_ADDR = 8'h93;
	localparam logic [7:0] ADDR_LEN  = 8'd6;
	localparam logic [7:0] ID_LEN    = 8'd4;

	// Result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_INCOMPLETE = 3'd1;
	localparam logic [2:0] ST_NO_SYNC2   = 3'd2;
	localparam logic [2:0] ST_BAD_END    = 3'd3;
	localparam logic [2:0] ST_BAD_CS     = 3'd4;
	localparam logic [2:0] ST_UNSUPP     = 3'd5;

	// Reading kinds
	localparam logic [2:0] KIND_ADDRESS = 3'd0;

	// Identifier registers, in index order
	localparam int          ID_COUNT        = 6;
	localparam logic [2:0]  REG_ID_VOLTAGE  = 3'd0;
	localparam logic [2:0]  REG_ID_CURRENT  = 3'd1;
	localparam logic [2:0]  REG_ID_POWER    = 3'd2;
	localparam logic [2:0]  REG_ID_ENERGY   = 3'd3;
	localparam logic [2:0]  REG_ID_FREQ     = 3'd4;
	localparam logic [2:0]  REG_ID_PF       = 3'd5;

	// Value byte weights (one BCD byte is two decimal digits)
	localparam logic [27:0] WEIGHT_1 = 28'd100;
	localparam logic [27:0] WEIGHT_2 = 28'd10000;
	localparam logic [27:0] WEIGHT_3 = 28'd1000000;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} byte_beat_t;

	typedef struct packed {
		logic        frame_ok;
		logic [2:0]  status;
		logic [7:0]  control_code;
		logic [47:0] meter_address;
		logic        address_captured;
		logic [2:0]  reading_kind;
		logic [27:0] reading_count;
	} result_t;

	// Reset value of each identifier register
	function automatic logic [31:0] id_reset(input logic [2:0] idx);
		logic [31:0] val;
		unique case (idx)
			REG_ID_VOLTAGE: val = 32'd33620224;
			REG_ID_CURRENT: val = 32'd33685760;
			REG_ID_POWER:   val = 32'd33751040;
			REG_ID_ENERGY:  val = 32'd0;
			REG_ID_FREQ:    val = 32'd41943042;
			REG_ID_PF:      val = 32'd34000896;
			default:        val = 32'd0;
		endcase
		return val;
	endfunction

	// Frame data length that each identifier register requires
	function automatic logic [7:0] kind_len(input logic [2:0] idx);
		logic [7:0] val;
		unique case (idx)
			REG_ID_VOLTAGE: val = 8'd6;
			REG_ID_CURRENT: val = 8'd7;
			REG_ID_POWER:   val = 8'd7;
			REG_ID_ENERGY:  val = 8'd8;
			REG_ID_FREQ:    val = 8'd6;
			REG_ID_PF:      val = 8'd6;
			default:        val = 8'd0;
		endcase
		return val;
	endfunction

	// Number of value bytes that each identifier register carries
	function automatic logic [2:0] kind_bytes(input logic [2:0] idx);
		logic [2:0] val;
		unique case (idx)
			REG_ID_VOLTAGE: val = 3'd2;
			REG_ID_CURRENT: val = 3'd3;
			REG_ID_POWER:   val = 3'd3;
			REG_ID_ENERGY:  val = 3'd4;
			REG_ID_FREQ:    val = 3'd2;
			REG_ID_PF:      val = 3'd2;
			default:        val = 3'd0;
		endcase
		return val;
	endfunction

	// One byte read as two decimal digits, high nibble * 10 + low nibble
	function automatic logic [7:0] bcd_byte(input logic [7:0] b);
		return 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
	endfunction

endpackage

>>> rtl/core/meter_response_frame_parser.sv
// Meter response frame parser: byte stream in, one result beat per receive buffer.
// An accepted byte goes to the input register, its result to the result register.
// Throughput: one byte per cycle; the input register stalls only while the result
// register holds an untaken beat. Reset (arst_n low) clears all control state and
// loads the identifier registers with their default identifiers.
// Depends on mrfp_pkg.
module meter_response_frame_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	// byte channel
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  mrfp_pkg::byte_beat_t byte_beat,
	// result channel
	output logic                 result_valid,
	input  logic                 result_ready,
	output mrfp_pkg::result_t    result,
	// configuration write port
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [31:0]          wr_data
);

	localparam logic [3:0] PH_HUNT    = 4'd0;
	localparam logic [3:0] PH_ADDR    = 4'd1;
	localparam logic [3:0] PH_SYNC2   = 4'd2;
	localparam logic [3:0] PH_CTRL    = 4'd3;
	localparam logic [3:0] PH_LEN     = 4'd4;
	localparam logic [3:0] PH_DATA    = 4'd5;
	localparam logic [3:0] PH_CS      = 4'd6;
	localparam logic [3:0] PH_END     = 4'd7;
	localparam logic [3:0] PH_BADSYNC = 4'd8;
	localparam logic [3:0] PH_DONE    = 4'd9;

	localparam logic [8:0] ADDR_BYTES    = 9'd6;
	localparam logic [8:0] BADSYNC_BYTES = 9'd4;

	// Identifier registers
	logic [31:0] id_q [mrfp_pkg::ID_COUNT];

	// Input register
	logic                 valid_s1;
	mrfp_pkg::byte_beat_t beat_s1;

	// Frame state
	logic [3:0]  phase_q;
	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [7:0]  ctrl_q;
	logic [7:0]  addr_q [6];
	logic [7:0]  sum_q;
	logic [7:0]  ident_q [4];
	logic [27:0] term_q [4];
	logic        answered_q;
	logic        cs_good_q;

	// Result register
	logic              res_valid_q;
	mrfp_pkg::result_t res_q;

	logic              out_free;
	logic              go;
	logic [7:0]        b;
	logic [7:0]        unmasked;
	logic [8:0]        pos_inc;
	logic [27:0]       new_term;
	logic              fire;
	mrfp_pkg::result_t res_d;
	mrfp_pkg::result_t decide_res;
	logic [47:0]       addr_word;
	logic [31:0]       ident_word;
	logic [5:0]        id_match;
	logic              id_hit;
	logic [2:0]        id_sel;
	logic [2:0]        val_bytes;
	logic [27:0]       value_sum;

	assign out_free     = !res_valid_q || result_ready;
	assign go           = valid_s1 && out_free;
	assign byte_ready   = !valid_s1 || out_free;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Write identifier registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mrfp_pkg::ID_COUNT; k++) begin
				id_q[k] <= mrfp_pkg::id_reset(3'(k));
			end
		end else if (wr_en && (32'(wr_index) < 32'(mrfp_pkg::ID_COUNT))) begin
			id_q[wr_index] <= wr_data;
		end
	end

	// Hold the incoming beat until the frame logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			beat_s1 <= byte_beat;
		end
	end

	// Decide a complete, well-formed frame from the held fields
	always_comb begin
		addr_word  = {addr_q[5], addr_q[4], addr_q[3], addr_q[2], addr_q[1], addr_q[0]};
		ident_word = {ident_q[3], ident_q[2], ident_q[1], ident_q[0]};
		for (int k = 0; k < mrfp_pkg::ID_COUNT; k++) begin
			id_match[k] = (ident_word == id_q[k]) && (len_q == mrfp_pkg::kind_len(3'(k)));
		end
		// lowest index wins
		id_hit = 1'b0;
		id_sel = 3'd0;
		for (int k = mrfp_pkg::ID_COUNT - 1; k >= 0; k--) begin
			if (id_match[k]) begin
				id_hit = 1'b1;
				id_sel = 3'(k);
			end
		end
		val_bytes = mrfp_pkg::kind_bytes(id_sel);
		value_sum = term_q[0] + term_q[1]
			+ ((val_bytes >= 3'd3) ? term_q[2] : 28'd0)
			+ ((val_bytes >= 3'd4) ? term_q[3] : 28'd0);

		decide_res                  = '0;
		decide_res.control_code     = ctrl_q;
		decide_res.meter_address    = addr_word;
		decide_res.address_captured = 1'b1;
		if (ctrl_q == mrfp_pkg::CTRL_ADDR && len_q == mrfp_pkg::ADDR_LEN) begin
			decide_res.frame_ok     = 1'b1;
			decide_res.status       = mrfp_pkg::ST_OK;
			decide_res.reading_kind = mrfp_pkg::KIND_ADDRESS;
		end else if ((ctrl_q == mrfp_pkg::CTRL_DATA || ctrl_q == mrfp_pkg::CTRL_ADDR)
				&& len_q >= mrfp_pkg::ID_LEN && id_hit) begin
			decide_res.frame_ok      = 1'b1;
			decide_res.status        = mrfp_pkg::ST_OK;
			decide_res.reading_kind  = id_sel + 3'd1;
			decide_res.reading_count = value_sum;
		end else begin
			decide_res.status = mrfp_pkg::ST_UNSUPP;
		end
	end

	// Weighted decimal term of a value byte, formed as it arrives
	always_comb begin
		b        = beat_s1.rx_byte;
		unmasked = b - mrfp_pkg::MASK_BYTE;
		pos_inc  = {1'b0, pos_q} + 9'd1;
		case (pos_q[1:0])
			2'd0:    new_term = {20'd0, mrfp_pkg::bcd_byte(unmasked)};
			2'd1:    new_term = 28'({20'd0, mrfp_pkg::bcd_byte(unmasked)} * mrfp_pkg::WEIGHT_1);
			2'd2:    new_term = 28'({20'd0, mrfp_pkg::bcd_byte(unmasked)} * mrfp_pkg::WEIGHT_2);
			default: new_term = 28'({20'd0, mrfp_pkg::bcd_byte(unmasked)} * mrfp_pkg::WEIGHT_3);
		endcase
	end

	// Result of the byte now in the input register
	always_comb begin
		fire  = 1'b0;
		res_d = '0;
		if (phase_q == PH_END) begin
			fire = 1'b1;
			if (b != mrfp_pkg::END_BYTE) begin
				res_d.status = mrfp_pkg::ST_BAD_END;
			end else if (!cs_good_q) begin
				res_d.status = mrfp_pkg::ST_BAD_CS;
			end else begin
				res_d = decide_res;
			end
		end else if (phase_q == PH_BADSYNC && pos_inc >= BADSYNC_BYTES) begin
			fire         = 1'b1;
			res_d.status = mrfp_pkg::ST_NO_SYNC2;
		end else if (beat_s1.last_byte && !answered_q) begin
			fire         = 1'b1;
			res_d.status = mrfp_pkg::ST_INCOMPLETE;
		end
	end

	// Advance the frame state machine by one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			pos_q      <= '0;
			len_q      <= '0;
			ctrl_q     <= '0;
			sum_q      <= '0;
			answered_q <= 1'b0;
			cs_good_q  <= 1'b0;
		end else if (go) begin
			if (beat_s1.last_byte) begin
				// buffer ends: back to hunting
				phase_q    <= PH_HUNT;
				pos_q      <= '0;
				len_q      <= '0;
				ctrl_q     <= '0;
				sum_q      <= '0;
				answered_q <= 1'b0;
				cs_good_q  <= 1'b0;
			end else begin
				unique case (phase_q)
					PH_HUNT: begin
						if (b == mrfp_pkg::SYNC_BYTE) begin
							phase_q <= PH_ADDR;
							pos_q   <= '0;
							sum_q   <= mrfp_pkg::SYNC_BYTE;
						end
					end
					PH_ADDR: begin
						sum_q <= sum_q + b;
						pos_q <= pos_inc[7:0];
						if (pos_inc >= ADDR_BYTES) begin
							phase_q <= PH_SYNC2;
						end
					end
					PH_SYNC2: begin
						sum_q   <= sum_q + b;
						pos_q   <= '0;
						phase_q <= (b == mrfp_pkg::SYNC_BYTE) ? PH_CTRL : PH_BADSYNC;
					end
					PH_CTRL: begin
						ctrl_q  <= b;
						sum_q   <= sum_q + b;
						phase_q <= PH_LEN;
					end
					PH_LEN: begin
						len_q   <= b;
						sum_q   <= sum_q + b;
						pos_q   <= '0;
						phase_q <= (b == 8'd0) ? PH_CS : PH_DATA;
					end
					PH_DATA: begin
						sum_q <= sum_q + b;
						pos_q <= pos_inc[7:0];
						if (pos_inc >= {1'b0, len_q}) begin
							phase_q <= PH_CS;
						end
					end
					PH_CS: begin
						cs_good_q <= (b == sum_q);
						phase_q   <= PH_END;
					end
					PH_END: begin
						answered_q <= 1'b1;
						phase_q    <= PH_DONE;
					end
					PH_BADSYNC: begin
						pos_q <= pos_inc[7:0];
						if (pos_inc >= BADSYNC_BYTES) begin
							answered_q <= 1'b1;
							phase_q    <= PH_DONE;
						end
					end
					PH_DONE: begin
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
		end
	end

	// Capture address, identifier and value bytes
	always_ff @(posedge clk) begin
		if (go && phase_q == PH_ADDR && pos_q < 8'd6) begin
			addr_q[pos_q[2:0]] <= b;
		end
		if (go && phase_q == PH_DATA && pos_q[7:2] == 6'd0) begin
			ident_q[pos_q[1:0]] <= unmasked;
		end
		if (go && phase_q == PH_DATA && pos_q[7:2] == 6'd1) begin
			term_q[pos_q[1:0]] <= new_term;
		end
	end

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && fire) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && fire) begin
			res_q <= res_d;
		end
	end

	// A buffer's last byte always returns the parser to hunting
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && beat_s1.last_byte) |=> (phase_q == PH_HUNT && !answered_q))
		else $error("parser did not return to hunting after last byte");

	// A new result beat appears only from a processed byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(go && fire))
		else $error("result beat without a processed byte");

	// The end byte of a frame marks the buffer answered
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && phase_q == PH_END && !beat_s1.last_byte) |=> (answered_q && phase_q == PH_DONE))
		else $error("end byte did not settle the frame");

endmodule

>>> tb/meter_response_frame_parser_tb.sv
// Testbench for meter_response_frame_parser: directed and random receive buffers,
// checked beat by beat against an in-bench frame predictor.
// Depends on mrfp_pkg and the meter_response_frame_parser RTL.
`timescale 1ns / 1ps

module meter_response_frame_parser_tb;

	localparam int         KEPT_BYTES = 8;
	localparam logic [2:0] KIND_VOLT  = 3'd1;

	typedef enum logic [3:0] {
		P_HUNT, P_ADDR, P_SYNC2, P_CTRL, P_LEN, P_DATA, P_CS, P_END, P_BADSYNC, P_DONE
	} parse_phase_t;

	// One receive buffer: optional junk, a frame, optional trailing bytes, optional cut
	typedef struct packed {
		logic [7:0]        lead;
		logic [47:0]       addr;
		logic [7:0]        sync2;
		logic [7:0]        ctrl;
		logic [7:0]        len;
		logic [31:0]       ident;
		logic [31:0]       value;
		logic [7:0]        cs_flip;
		logic [7:0]        stop;
		logic [15:0]       cut;
		logic [7:0]        tail;
		logic              typed;
		mrfp_pkg::result_t want;
	} frame_spec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_ready;
	mrfp_pkg::byte_beat_t byte_beat = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	mrfp_pkg::result_t    result;
	logic                 wr_en = 1'b0;
	logic [2:0]           wr_index = '0;
	logic [31:0]          wr_data = '0;

	// Predictor copy of the identifier registers and frame state
	logic [31:0]  id_reg [6];
	logic [7:0]   need_len [6] = '{8'd6, 8'd7, 8'd7, 8'd8, 8'd6, 8'd6};
	parse_phase_t ph;
	logic [7:0]   pos;
	logic [7:0]   dlen;
	logic [7:0]   ctl;
	logic [47:0]  adr;
	logic [7:0]   csum;
	logic [7:0]   store [KEPT_BYTES];
	logic         answered;
	logic         cs_ok;

	mrfp_pkg::result_t frame_answers [$];
	logic              pin_active = 1'b0;
	mrfp_pkg::result_t pinned = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_sent = 0;
	int buffers_sent = 0;
	int answers_seen = 0;
	int readings_seen = 0;
	int fail_count = 0;

	meter_response_frame_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_beat    (byte_beat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #10 clk = ~clk;

	// Bound the run
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic mrfp_pkg::result_t fault(logic [2:0] st);
		mrfp_pkg::result_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	// Decide a frame that passed the end byte and checksum checks
	function automatic mrfp_pkg::result_t judge_frame();
		mrfp_pkg::result_t r;
		logic [31:0]       ident;
		int unsigned       v;
		r = '0;
		r.control_code = ctl;
		r.meter_address = adr;
		r.address_captured = 1'b1;
		r.status = mrfp_pkg::ST_UNSUPP;
		if (ctl == mrfp_pkg::CTRL_ADDR && dlen == mrfp_pkg::ADDR_LEN) begin
			r.frame_ok = 1'b1;
			r.status = mrfp_pkg::ST_OK;
			r.reading_kind = mrfp_pkg::KIND_ADDRESS;
			return r;
		end
		if ((ctl == mrfp_pkg::CTRL_DATA || ctl == mrfp_pkg::CTRL_ADDR)
				&& dlen >= mrfp_pkg::ID_LEN) begin
			ident = {store[3], store[2], store[1], store[0]};
			// first matching identifier with the right length wins
			for (int k = 0; k < mrfp_pkg::ID_COUNT; k++) begin
				if (ident == id_reg[k] && dlen == need_len[k]) begin
					v = 0;
					for (int i = int'(need_len[k]) - 1; i >= int'(mrfp_pkg::ID_LEN); i--)
						v = v * 100 + store[i][7:4] * 10 + store[i][3:0];
					r.frame_ok = 1'b1;
					r.status = mrfp_pkg::ST_OK;
					r.reading_kind = KIND_VOLT + 3'(k);
					r.reading_count = 28'(v);
					return r;
				end
			end
		end
		return r;
	endfunction

	task automatic clear_frame();
		ph = P_HUNT;
		pos = '0;
		dlen = '0;
		ctl = '0;
		adr = '0;
		csum = '0;
		store = '{default: 8'h00};
		answered = 1'b0;
		cs_ok = 1'b0;
	endtask

	// Advance the predictor by one accepted byte beat
	task automatic track_byte(logic [7:0] b, logic last);
		mrfp_pkg::result_t r;
		logic              give;
		r = '0;
		give = 1'b0;
		case (ph)
			P_HUNT: begin
				if (b == mrfp_pkg::SYNC_BYTE) begin
					ph = P_ADDR;
					pos = '0;
					csum = mrfp_pkg::SYNC_BYTE;
				end
			end
			P_ADDR: begin
				adr[int'(pos) * 8 +: 8] = b;
				csum += b;
				pos++;
				if (pos >= 8'd6)
					ph = P_SYNC2;
			end
			P_SYNC2: begin
				csum += b;
				pos = '0;
				ph = (b == mrfp_pkg::SYNC_BYTE) ? P_CTRL : P_BADSYNC;
			end
			P_CTRL: begin
				ctl = b;
				csum += b;
				ph = P_LEN;
			end
			P_LEN: begin
				dlen = b;
				csum += b;
				pos = '0;
				ph = (b == 8'd0) ? P_CS : P_DATA;
			end
			P_DATA: begin
				if (pos < KEPT_BYTES)
					store[pos] = b - mrfp_pkg::MASK_BYTE;
				csum += b;
				pos++;
				if (pos >= dlen)
					ph = P_CS;
			end
			P_CS: begin
				cs_ok = (b == csum);
				ph = P_END;
			end
			P_END: begin
				// end byte is judged before the checksum
				if (b != mrfp_pkg::END_BYTE)
					r = fault(mrfp_pkg::ST_BAD_END);
				else if (!cs_ok)
					r = fault(mrfp_pkg::ST_BAD_CS);
				else
					r = judge_frame();
				give = 1'b1;
				answered = 1'b1;
				ph = P_DONE;
			end
			P_BADSYNC: begin
				pos++;
				if (pos >= 8'd4) begin
					r = fault(mrfp_pkg::ST_NO_SYNC2);
					give = 1'b1;
					answered = 1'b1;
					ph = P_DONE;
				end
			end
			default: ;
		endcase
		if (last) begin
			if (!answered) begin
				r = fault(mrfp_pkg::ST_INCOMPLETE);
				give = 1'b1;
			end
			clear_frame();
		end
		if (give)
			frame_answers.push_back(pin_active ? pinned : r);
	endtask

	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == mrfp_pkg::SYNC_BYTE)
			b = ~b;
		return b;
	endfunction

	function automatic frame_spec_t frm(logic [7:0] lead, logic [47:0] addr, logic [7:0] sync2,
			logic [7:0] ctrl, logic [7:0] len, logic [31:0] ident, logic [31:0] value,
			logic [7:0] cs_flip, logic [7:0] stop, logic [15:0] cut, logic [7:0] tail);
		frame_spec_t s;
		s = '0;
		s.lead = lead;
		s.addr = addr;
		s.sync2 = sync2;
		s.ctrl = ctrl;
		s.len = len;
		s.ident = ident;
		s.value = value;
		s.cs_flip = cs_flip;
		s.stop = stop;
		s.cut = cut;
		s.tail = tail;
		return s;
	endfunction

	function automatic frame_spec_t pin(frame_spec_t s, mrfp_pkg::result_t want);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	// Mostly well-formed frames with random content; the rest broken or noise
	function automatic frame_spec_t random_frame();
		frame_spec_t s;
		int          k;
		int          roll;
		int          sz;
		k = $urandom_range(mrfp_pkg::ID_COUNT - 1);
		s = frm(($urandom_range(9) < 3) ? 8'($urandom_range(1, 3)) : 8'd0,
			{16'($urandom), 32'($urandom)}, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA,
			need_len[k], id_reg[k], 32'd0, 8'd0, mrfp_pkg::END_BYTE, 16'd0,
			($urandom_range(3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0);
		roll = $urandom_range(99);
		if (roll >= 80)
			s.ctrl = 8'($urandom);
		else if (roll >= 45)
			s.ctrl = mrfp_pkg::CTRL_ADDR;
		if ($urandom_range(9) < 7) begin
			for (int i = 0; i < 8; i++)
				s.value[4 * i +: 4] = 4'($urandom_range(9));
		end else begin
			s.value = $urandom;
		end
		roll = $urandom_range(99);
		if (roll < 10)
			s.ident = $urandom;
		else if (roll < 20)
			s.len = 8'($urandom_range(0, 10));
		else if (roll < 22)
			s.len = 8'($urandom_range(11, 255));
		else if (roll < 30) begin
			s.ctrl = mrfp_pkg::CTRL_ADDR;
			s.len = mrfp_pkg::ADDR_LEN;
		end
		roll = $urandom_range(99);
		if (roll >= 70 && roll < 75)
			s.sync2 = junk_byte();
		else if (roll >= 75 && roll < 80)
			s.stop = ~mrfp_pkg::END_BYTE ^ 8'($urandom_range(1, 255));
		else if (roll >= 80 && roll < 85)
			s.cs_flip = 8'($urandom_range(1, 255));
		else if (roll >= 85 && roll < 88) begin
			s.stop = mrfp_pkg::END_BYTE ^ 8'($urandom_range(1, 255));
			s.cs_flip = 8'($urandom_range(1, 255));
		end else if (roll >= 88 && roll < 96) begin
			sz = int'(s.lead) + 12 + int'(s.len) + int'(s.tail);
			s.cut = 16'($urandom_range(1, sz - 1));
		end else if (roll >= 96) begin
			s.lead = 8'($urandom_range(1, 12));
			s.cut = 16'(s.lead);
		end
		if (s.stop == mrfp_pkg::END_BYTE && roll >= 75 && roll < 80)
			s.stop = 8'h00;
		return s;
	endfunction

	// Build one buffer and push it through the byte channel
	task automatic send_buffer(frame_spec_t s);
		logic [7:0] q [$];
		logic [7:0] sum;
		logic [7:0] raw;
		repeat (s.lead)
			q.push_back(junk_byte());
		sum = mrfp_pkg::SYNC_BYTE;
		q.push_back(mrfp_pkg::SYNC_BYTE);
		for (int i = 0; i < 6; i++) begin
			q.push_back(s.addr[8 * i +: 8]);
			sum += s.addr[8 * i +: 8];
		end
		q.push_back(s.sync2);
		q.push_back(s.ctrl);
		q.push_back(s.len);
		sum += s.sync2 + s.ctrl + s.len;
		for (int i = 0; i < int'(s.len); i++) begin
			if (i < 4)
				raw = s.ident[8 * i +: 8];
			else if (i < 8)
				raw = s.value[8 * (i - 4) +: 8];
			else
				raw = 8'($urandom);
			q.push_back(raw + mrfp_pkg::MASK_BYTE);
			sum += raw + mrfp_pkg::MASK_BYTE;
		end
		q.push_back(sum ^ s.cs_flip);
		q.push_back(s.stop);
		repeat (s.tail)
			q.push_back(8'($urandom));
		while (s.cut != 0 && q.size() > int'(s.cut))
			void'(q.pop_back());

		pin_active = s.typed;
		pinned = s.want;
		for (int i = 0; i < q.size(); i++) begin
			// idle the sender between beats
			if ($urandom_range(99) < send_idle_pct) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			byte_valid <= 1'b1;
			byte_beat <= '{rx_byte: q[i], last_byte: (i == q.size() - 1)};
			@(posedge clk);
			while (!byte_ready)
				@(posedge clk);
			track_byte(q[i], i == q.size() - 1);
			bytes_sent++;
		end
		pin_active = 1'b0;
		buffers_sent++;
	endtask

	// Drop valid, wait for every answer, then let the pipeline empty
	task automatic drain();
		byte_valid <= 1'b0;
		while (frame_answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all identifier registers from the predictor copy
	task automatic load_ids();
		for (int i = 0; i < mrfp_pkg::ID_COUNT; i++) begin
			wr_en <= 1'b1;
			wr_index <= mrfp_pkg::REG_ID_VOLTAGE + 3'(i);
			wr_data <= id_reg[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic run_random(int budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget)
			send_buffer(random_frame());
		drain();
	endtask

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Result side: random stall, compare each beat with the oldest answer
	always @(posedge clk) begin : take_results
		mrfp_pkg::result_t want;
		if (result_valid === 1'b1 && result_ready) begin
			answers_seen++;
			if (frame_answers.size() == 0) begin
				$error("result beat with no answer pending: %p", result);
				fail_count++;
			end else begin
				want = frame_answers.pop_front();
				if (want.frame_ok && want.reading_kind != mrfp_pkg::KIND_ADDRESS)
					readings_seen++;
				check_field("frame_ok", want.frame_ok, result.frame_ok);
				check_field("status", want.status, result.status);
				check_field("control_code", want.control_code, result.control_code);
				check_field("meter_address", want.meter_address, result.meter_address);
				check_field("address_captured", want.address_captured,
					result.address_captured);
				check_field("reading_kind", want.reading_kind, result.reading_kind);
				check_field("reading_count", want.reading_count, result.reading_count);
			end
		end
		result_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin : stimulus
		frame_spec_t rows [$];
		id_reg = '{32'h0201_0100, 32'h0202_0100, 32'h0203_0000, 32'h0000_0000,
			32'h0280_0002, 32'h0206_D000};
		clear_frame();
		send_idle_pct = 26;
		recv_idle_pct = 49;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed buffers under the reset identifiers
		rows.push_back(pin(frm(8'd5, 48'h0, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd0,
			32'h0, 32'h0, 8'h00, mrfp_pkg::END_BYTE, 16'd5, 8'd0),
			fault(mrfp_pkg::ST_INCOMPLETE)));
		rows.push_back(pin(frm(8'd0, 48'h6655_4433_2211, mrfp_pkg::SYNC_BYTE,
			mrfp_pkg::CTRL_ADDR, mrfp_pkg::ADDR_LEN, 32'h0, 32'h0, 8'h00,
			mrfp_pkg::END_BYTE, 16'd0, 8'd0),
			mrfp_pkg::result_t'{1'b1, mrfp_pkg::ST_OK, mrfp_pkg::CTRL_ADDR,
			48'h6655_4433_2211, 1'b1, mrfp_pkg::KIND_ADDRESS, 28'd0}));
		rows.push_back(pin(frm(8'd0, 48'h1, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h00, mrfp_pkg::END_BYTE, 16'd0,
			8'd0),
			mrfp_pkg::result_t'{1'b1, mrfp_pkg::ST_OK, mrfp_pkg::CTRL_DATA, 48'h1, 1'b1,
			KIND_VOLT, 28'd2200}));
		rows.push_back(frm(8'd1, 48'hA5A5_5A5A_0F0F, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA,
			8'd7, id_reg[mrfp_pkg::REG_ID_CURRENT], 32'h01_2345, 8'h00, mrfp_pkg::END_BYTE,
			16'd0, 8'd0));
		rows.push_back(frm(8'd0, 48'h0000_1234_5678, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_ADDR,
			8'd7, id_reg[mrfp_pkg::REG_ID_POWER], 32'h98_7654, 8'h00, mrfp_pkg::END_BYTE,
			16'd0, 8'd0));
		rows.push_back(frm(8'd0, 48'h0, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd8,
			id_reg[mrfp_pkg::REG_ID_ENERGY], 32'h9999_9999, 8'h00, mrfp_pkg::END_BYTE,
			16'd0, 8'd0));
		rows.push_back(frm(8'd0, 48'h0102_0304_0506, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA,
			8'd6, id_reg[mrfp_pkg::REG_ID_FREQ], 32'h5000, 8'h00, mrfp_pkg::END_BYTE,
			16'd0, 8'd2));
		rows.push_back(frm(8'd0, 48'h0102_0304_0506, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA,
			8'd6, id_reg[mrfp_pkg::REG_ID_PF], 32'h0985, 8'h00, mrfp_pkg::END_BYTE,
			16'd0, 8'd0));
		// non-decimal nibbles give the largest count
		rows.push_back(frm(8'd0, 48'hFFFF_FFFF_FFFF, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA,
			8'd8, id_reg[mrfp_pkg::REG_ID_ENERGY], 32'hFFFF_FFFF, 8'h00, mrfp_pkg::END_BYTE,
			16'd0, 8'd0));
		rows.push_back(frm(8'd0, 48'h1, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd7,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h1234, 8'h00, mrfp_pkg::END_BYTE, 16'd0,
			8'd0));
		rows.push_back(frm(8'd0, 48'h2, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			32'hDEAD_BEEF, 32'h1234, 8'h00, mrfp_pkg::END_BYTE, 16'd0, 8'd0));
		rows.push_back(frm(8'd0, 48'h3, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd3,
			32'h0, 32'h0, 8'h00, mrfp_pkg::END_BYTE, 16'd0, 8'd0));
		rows.push_back(frm(8'd0, 48'h4, mrfp_pkg::SYNC_BYTE, 8'h00, 8'd0, 32'h0, 32'h0,
			8'h00, mrfp_pkg::END_BYTE, 16'd0, 8'd0));
		rows.push_back(frm(8'd0, 48'h5, mrfp_pkg::SYNC_BYTE, 8'hFF, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h00, mrfp_pkg::END_BYTE, 16'd0,
			8'd0));
		rows.push_back(frm(8'd0, 48'h6, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd255,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h00, mrfp_pkg::END_BYTE, 16'd0,
			8'd0));
		rows.push_back(pin(frm(8'd0, 48'h7, 8'h00, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h00, mrfp_pkg::END_BYTE, 16'd0,
			8'd0), fault(mrfp_pkg::ST_NO_SYNC2)));
		// buffer ends two bytes past a bad second sync
		rows.push_back(pin(frm(8'd0, 48'h8, 8'hFF, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h00, mrfp_pkg::END_BYTE, 16'd10,
			8'd0), fault(mrfp_pkg::ST_INCOMPLETE)));
		rows.push_back(pin(frm(8'd0, 48'h9, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h00, 8'h00, 16'd0, 8'd0),
			fault(mrfp_pkg::ST_BAD_END)));
		rows.push_back(pin(frm(8'd0, 48'hA, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h01, mrfp_pkg::END_BYTE, 16'd0,
			8'd0), fault(mrfp_pkg::ST_BAD_CS)));
		// bad end byte and bad checksum together
		rows.push_back(pin(frm(8'd0, 48'hB, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h80, 8'hFF, 16'd0, 8'd0),
			fault(mrfp_pkg::ST_BAD_END)));
		rows.push_back(pin(frm(8'd0, 48'hC, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h2200, 8'h00, mrfp_pkg::END_BYTE, 16'd14,
			8'd0), fault(mrfp_pkg::ST_INCOMPLETE)));
		rows.push_back(pin(frm(8'd0, 48'hD, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			32'h0, 32'h0, 8'h00, mrfp_pkg::END_BYTE, 16'd1, 8'd0),
			fault(mrfp_pkg::ST_INCOMPLETE)));
		rows.push_back(frm(8'd3, 48'hE, mrfp_pkg::SYNC_BYTE, mrfp_pkg::CTRL_DATA, 8'd6,
			id_reg[mrfp_pkg::REG_ID_VOLTAGE], 32'h0123, 8'h00, mrfp_pkg::END_BYTE, 16'd0,
			8'd4));
		foreach (rows[i])
			send_buffer(rows[i]);
		drain();

		// Random identifiers
		for (int i = 0; i < mrfp_pkg::ID_COUNT; i++)
			id_reg[i] = $urandom;
		load_ids();
		run_random(150);

		// All-zero identifiers: every kind shares one id, order decides
		send_idle_pct = 49;
		recv_idle_pct = 26;
		id_reg = '{default: 32'h0000_0000};
		load_ids();
		run_random(150);

		id_reg = '{default: 32'hFFFF_FFFF};
		load_ids();
		run_random(150);

		// Random identifiers with shadowed duplicates, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < mrfp_pkg::ID_COUNT; i++)
			id_reg[i] = $urandom;
		id_reg[mrfp_pkg::REG_ID_POWER] = id_reg[mrfp_pkg::REG_ID_CURRENT];
		id_reg[mrfp_pkg::REG_ID_FREQ] = id_reg[mrfp_pkg::REG_ID_VOLTAGE];
		load_ids();
		run_random(150);

		$display("tb: %0d bytes in %0d buffers, five identifier sets, three pacing modes",
			bytes_sent, buffers_sent);
		$display("tb: %0d result beats checked, %0d decoded readings",
			answers_seen, readings_seen);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
